### src/text_cell_writer_with_color_escapes_top_assert.svh
// Assertion macros for the text cell writer.
// The clock is clk and the reset is arst_n in every module that uses them.
`ifndef TEXT_CELL_WRITER_WITH_COLOR_ESCAPES_TOP_ASSERT_SVH
`define TEXT_CELL_WRITER_WITH_COLOR_ESCAPES_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Checked outside reset only.
`define TCW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define TCW_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCW_ASSERT(label, prop, msg)
`define TCW_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

### src/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

	localparam int CHAR_W     = 8;
	localparam int CELL_IDX_W = 11;
	localparam int ATTR_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_ESC_EN      = cfg_idx_t'(0);
	localparam cfg_idx_t REG_PLAIN_COLOR = cfg_idx_t'(1);

	localparam logic [CHAR_W-1:0] CHAR_HASH    = 8'h23;
	localparam logic [CHAR_W-1:0] CHAR_NL      = 8'h0A;
	localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'h07;

	// Parser phase: plain text, after '#', after the high digit.
	typedef enum logic [1:0] {
		PH_TEXT = 2'd0,
		PH_HASH = 2'd1,
		PH_HIGH = 2'd2
	} esc_phase_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_digit_t;

	// Cursor moves requested for one processed character.
	typedef struct packed {
		logic step;
		logic newline;
	} cursor_cmd_t;

	function automatic hex_digit_t hex_decode(input logic [CHAR_W-1:0] c);
		hex_digit_t d;
		d.valid = 1'b1;
		d.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d.value = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d.value = 4'(c - 8'h41 + 8'h0A);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d.value = 4'(c - 8'h61 + 8'h0A);
		end else begin
			d.valid = 1'b0;
		end
		return d;
	endfunction

endpackage
`default_nettype wire

### src/tcw_char_if.sv
`default_nettype none
interface tcw_char_if import tcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              string_start;

	modport source (output valid, output char_code, output string_start, input ready);
	modport sink (input valid, input char_code, input string_start, output ready);
endinterface
`default_nettype wire

### src/tcw_cell_if.sv
`default_nettype none
interface tcw_cell_if import tcw_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CELL_IDX_W-1:0] cell_index;
	logic [CHAR_W-1:0]     glyph;
	logic [ATTR_W-1:0]     attribute;

	modport source (output valid, output cell_index, output glyph, output attribute,
		input ready);
	modport sink (input valid, input cell_index, input glyph, input attribute,
		output ready);
endinterface
`default_nettype wire

### src/tcw_cfg_if.sv
`default_nettype none
interface tcw_cfg_if import tcw_pkg::*; ();
	logic                  valid;
	logic                  ready;
	cfg_idx_t              index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### src/tcw_cursor.sv
`default_nettype none
// Screen cursor: linear cell number plus column, wraps at the screen end.
module tcw_cursor import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	localparam int TOTAL  = ROWS * COLUMNS,
	localparam int CELL_W = $clog2(TOTAL + COLUMNS + 1),
	localparam int COL_W  = $clog2(COLUMNS + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cursor_cmd_t       cmd,
	output logic      [CELL_W-1:0] cell_num,
	output logic      [COL_W-1:0]  column
);

	logic [CELL_W-1:0] cell_q, cell_inc, cell_nl;
	logic [COL_W-1:0]  col_q, col_inc;

	assign cell_inc = cell_q + CELL_W'(1);
	assign col_inc  = col_q + COL_W'(1);
	// newline: jump to column 0 of the next row
	assign cell_nl  = cell_q + CELL_W'(COLUMNS) - CELL_W'(col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
			col_q  <= '0;
		end else if (cmd.step) begin
			if (cell_inc >= CELL_W'(TOTAL)) begin
				cell_q <= '0;
				col_q  <= '0;
			end else begin
				cell_q <= cell_inc;
				col_q  <= (col_inc >= COL_W'(COLUMNS)) ? '0 : col_inc;
			end
		end else if (cmd.newline) begin
			cell_q <= (cell_nl >= CELL_W'(TOTAL)) ? '0 : cell_nl;
			col_q  <= '0;
		end
	end

	assign cell_num = cell_q;
	assign column   = col_q;

endmodule
`default_nettype wire

### src/text_cell_writer_with_color_escapes_top.sv
// Channel | Dir | Transaction payload
// chars   | in  | char_code[7:0], string_start
// cells   | out | cell_index[10:0], glyph[7:0], attribute[7:0]
// cfg     | in  | index[1:0] (0 escapes_enabled, 1 plain_color), data[7:0]
//
// One character per cycle sustained while cells is ready. A character passes the input register,
// then the parse/cursor logic loads the output register if it emits a cell.
// The parser phase, color and cursor update in the same cycle the output
// register is loaded, so back-to-back characters see each other's effects.
// arst_n clears the cursor, parser phase, color and config to reset values.
// A stalled cells channel holds its result; chars keeps flowing until the
// input register is also occupied. cfg is always ready.
`default_nettype none
`include "text_cell_writer_with_color_escapes_top_assert.svh"
module text_cell_writer_with_color_escapes_top import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input wire logic   clk,
	input wire logic   arst_n,
	tcw_char_if.sink   chars,
	tcw_cell_if.source cells,
	tcw_cfg_if.sink    cfg
);

	localparam int TOTAL  = ROWS * COLUMNS;
	localparam int CELL_W = $clog2(TOTAL + COLUMNS + 1);
	localparam int COL_W  = $clog2(COLUMNS + 1);

	// configuration registers
	logic              esc_en_q;
	logic [ATTR_W-1:0] plain_color_q;

	// input stage
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              start_s1;

	// parser state
	esc_phase_t        phase_q, phase_n, phase_base;
	logic [ATTR_W-1:0] color_q, color_n, color_base;

	// output stage
	logic                  cells_valid_q;
	logic [CELL_IDX_W-1:0] cell_idx_q;
	logic [CHAR_W-1:0]     glyph_q;
	logic [ATTR_W-1:0]     attr_q;

	logic              advance, chars_take, emit, plain_emit;
	logic [ATTR_W-1:0] emit_attr;
	hex_digit_t        digit;
	cursor_cmd_t       cmd, cmd_gated;
	logic [CELL_W-1:0] cur_cell;
	logic [COL_W-1:0]  cur_col;
	logic [31:0]       cell_ext;

	// Process the held character whenever the output register is free or draining.
	assign advance    = valid_s1 && (!cells_valid_q || cells.ready);
	assign chars.ready = !valid_s1 || advance;
	assign chars_take = chars.valid && chars.ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_en_q      <= 1'b1;
			plain_color_q <= DEFAULT_ATTR;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_ESC_EN:      esc_en_q <= cfg.data[0];
				REG_PLAIN_COLOR: plain_color_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars_take) begin
			char_s1  <= chars.char_code;
			start_s1 <= chars.string_start;
		end
	end

	// Parser: string start resets color and phase before the character is seen.
	always_comb begin
		digit      = hex_decode(char_s1);
		phase_base = start_s1 ? PH_TEXT : phase_q;
		color_base = start_s1 ? DEFAULT_ATTR : color_q;
		phase_n    = phase_base;
		color_n    = color_base;
		emit       = 1'b0;
		emit_attr  = color_base;
		cmd        = '0;
		if (!esc_en_q) begin
			phase_n = PH_TEXT;
			if (char_s1 == CHAR_NL) begin
				cmd.newline = 1'b1;
			end else begin
				emit      = 1'b1;
				emit_attr = plain_color_q;
			end
		end else begin
			unique case (phase_base)
				PH_HASH: begin
					if (char_s1 == CHAR_HASH) begin
						// "##" prints a literal hash
						phase_n = PH_TEXT;
						emit    = 1'b1;
					end else begin
						if (digit.valid) color_n = {digit.value, 4'd0};
						phase_n = PH_HIGH;
					end
				end
				PH_HIGH: begin
					if (digit.valid) color_n = color_base + {4'd0, digit.value};
					phase_n = PH_TEXT;
				end
				default: begin
					// normal text; the unused phase code lands here too
					phase_n = PH_TEXT;
					if (char_s1 == CHAR_HASH) begin
						phase_n = PH_HASH;
					end else if (char_s1 == CHAR_NL) begin
						cmd.newline = 1'b1;
					end else begin
						emit = 1'b1;
					end
				end
			endcase
		end
		cmd.step = emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TEXT;
			color_q <= DEFAULT_ATTR;
		end else if (advance) begin
			phase_q <= phase_n;
			color_q <= color_n;
		end
	end

	assign cmd_gated = advance ? cmd : '0;

	tcw_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_cursor (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_gated),
		.cell_num(cur_cell),
		.column  (cur_col)
	);

	// cell number zero-extended to 32 bits; its low 11 bits feed the cell index
	assign cell_ext = 32'(cur_cell);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_valid_q <= 1'b0;
		end else if (advance) begin
			cells_valid_q <= emit;
		end else if (cells.ready) begin
			cells_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			cell_idx_q <= cell_ext[CELL_IDX_W-1:0];
			glyph_q    <= char_s1;
			attr_q     <= emit_attr;
		end
	end

	assign cells.valid      = cells_valid_q;
	assign cells.cell_index = cell_idx_q;
	assign cells.glyph      = glyph_q;
	assign cells.attribute  = attr_q;

	assign plain_emit = advance && emit && !esc_en_q;

	`TCW_ASSERT_ALWAYS(a_cursor_in_range, cur_cell < CELL_W'(TOTAL), "cursor past screen end")
	`TCW_ASSERT(a_col_in_range, cur_col < COL_W'(COLUMNS), "cursor column past row end")
	`TCW_ASSERT(a_nl_col_zero, advance && cmd.newline |=> cur_col == '0, "newline left column")
	`TCW_ASSERT(a_full_stall, valid_s1 && !advance |-> !chars.ready, "input taken while full")
	`TCW_ASSERT(a_plain_attr, plain_emit |=> attr_q == $past(plain_color_q), "plain attr wrong")

endmodule
`default_nettype wire
